>>> rtl/pnrg_pkg.sv
// Package for the pink noise row generator.
// Holds default sizes, the configuration width and the sequencer state type.
// No dependencies.
package pnrg_pkg;

  localparam int MAX_ROWS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 6;
  localparam int ROW_COUNT_RST   = 16;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DIV   = 3'b100
  } state_t;

endpackage

>>> rtl/pink_noise_row_generator_top.sv
// Top level of the pink noise row generator (Voss-McCartney 1/f noise).
// Depends on pnrg_pkg for defaults, the config width and the state type.
//
// Each input transfer is one tick carrying a fresh uniform sample; it returns
// the noise value computed on the previous tick, then updates one row and
// computes the next value. The rows sit in a circular shift register that
// makes one full turn per tick, during which the row search runs
// bit-serially over the tick counter and the active rows are summed. The
// mean is then formed by a restoring divider that makes one quotient bit per
// cycle. A new sample is only accepted once the division of the current tick
// has finished.
// The output transfer is held in a register, so a stalled output only blocks
// the next tick, not the computation of the current one.
module pink_noise_row_generator_top #(
  parameter int MAX_ROWS    = pnrg_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = pnrg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pnrg_pkg::CFG_W-1:0]          cfg_wdata,    // row_count
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata, // random_sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata  // noise_value
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int COUNT_W = $clog2(MAX_ROWS + 1);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_ROWS);
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int RST_ROWS =
    (pnrg_pkg::ROW_COUNT_RST > MAX_ROWS) ? MAX_ROWS : pnrg_pkg::ROW_COUNT_RST;

  pnrg_pkg::state_t state;

  logic [SAMPLE_BITS-1:0] rows [MAX_ROWS];
  logic [MAX_ROWS-1:0]    counter;
  logic [MAX_ROWS-1:0]    cnt_sh;
  logic                   zflag;
  logic [COUNT_W-1:0]     row_count;
  logic [COUNT_W-1:0]     k;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       dvd;
  logic [COUNT_W-1:0]     rem;
  logic [DCNT_W-1:0]      dcnt;
  logic [SAMPLE_BITS-1:0] held;
  logic [SAMPLE_BITS-1:0] out_data;

  logic                   accept;
  logic                   active;
  logic                   last_row;
  logic                   hit;
  logic [SAMPLE_BITS-1:0] new_head;
  logic [SUM_W-1:0]       sum_next;
  logic [COUNT_W:0]       trial;
  logic                   qbit;
  logic [COUNT_W-1:0]     cfg_rows;

  assign s_axis_tready = (state == pnrg_pkg::ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = TDATA_W'(out_data);

  // row search: row k takes the sample when all lower counter bits are zero
  // and either bit k is set or k is the top active row
  assign active   = k < row_count;
  assign last_row = k == (row_count - COUNT_W'(1));
  assign hit      = active && zflag && (cnt_sh[0] || last_row);
  assign new_head = hit ? sample : rows[0];
  assign sum_next = active ? (sum + SUM_W'(new_head)) : sum;

  assign trial = {rem, dvd[SUM_W-1]};
  assign qbit  = trial >= {1'b0, row_count};

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_rows = COUNT_W'(1);
    end else if (cfg_wdata > pnrg_pkg::CFG_W'(MAX_ROWS)) begin
      cfg_rows = COUNT_W'(MAX_ROWS);
    end else begin
      cfg_rows = COUNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pnrg_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      row_count     <= COUNT_W'(RST_ROWS);
      counter       <= '0;
      held          <= '0;
      for (int j = 0; j < MAX_ROWS; j++) begin
        rows[j] <= '0;
      end
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        row_count <= cfg_rows;
        counter   <= '0;
      end
      unique case (state)
        pnrg_pkg::ST_IDLE: begin
          if (accept) begin
            m_axis_tvalid <= 1'b1;
            out_data      <= held;
            sample        <= s_axis_tdata[SAMPLE_BITS-1:0];
            counter       <= counter + MAX_ROWS'(1);
            cnt_sh        <= counter + MAX_ROWS'(1);
            zflag         <= 1'b1;
            k             <= '0;
            sum           <= '0;
            state         <= pnrg_pkg::ST_SWEEP;
          end
        end
        pnrg_pkg::ST_SWEEP: begin
          for (int j = 0; j < MAX_ROWS - 1; j++) begin
            rows[j] <= rows[j+1];
          end
          rows[MAX_ROWS-1] <= new_head;
          if (hit && last_row) begin
            counter <= '0;
          end
          zflag  <= zflag & ~cnt_sh[0];
          cnt_sh <= cnt_sh >> 1;
          sum    <= sum_next;
          k      <= k + COUNT_W'(1);
          if (k == COUNT_W'(MAX_ROWS - 1)) begin
            dvd   <= sum_next;
            rem   <= '0;
            dcnt  <= '0;
            state <= pnrg_pkg::ST_DIV;
          end
        end
        pnrg_pkg::ST_DIV: begin
          // restoring division, quotient bits shift in at the bottom of dvd
          rem  <= qbit ? COUNT_W'(trial - {1'b0, row_count}) : trial[COUNT_W-1:0];
          dvd  <= {dvd[SUM_W-2:0], qbit};
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(SUM_W - 1)) begin
            held  <= {dvd[SAMPLE_BITS-2:0], qbit};
            state <= pnrg_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pnrg_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
